FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the degree tracker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/amdt_pkg.sv
// Types, constants and action codes of the adjacency matrix degree tracker.
// Used by amdt_store, amdt_ctrl and the top level; depends on nothing.
`default_nettype none

package amdt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int STORE_ROWS   = 64;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int DEG_W        = 7;
    localparam int HDEG_W       = 6;

    typedef logic [VTX_W-1:0]      t_vtx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DEG_W-1:0]      t_deg;
    typedef logic [STORE_ROWS-1:0] t_row;

    typedef enum logic [2:0] {
        ACT_ADD_VERTEX = 3'd0,
        ACT_ADD_EDGE   = 3'd1,
        ACT_REMOVE     = 3'd2,
        ACT_QUERY      = 3'd3,
        ACT_FIND       = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_QUERY,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // One memory word: a vertex's degree beside its adjacency row.
    typedef struct packed {
        t_deg deg;
        t_row row;
    } t_entry;

    typedef struct packed {
        logic   rd_en;
        t_vtx   rd_addr;
        logic   wr_en;
        t_vtx   wr_addr;
        t_entry wr_data;
    } t_mem_req;

    typedef struct packed {
        logic [2:0] action;
        t_vtx       vertex_a;
        t_vtx       vertex_b;
    } t_cmd;

    typedef struct packed {
        logic              status;
        logic              adjacent;
        logic              found;
        t_vtx              isolated_vertex;
        t_cnt              vertex_count;
        logic [HDEG_W-1:0] highest_degree;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/amdt_store.sv
// Vertex store: one synchronous memory of {degree, adjacency row} words.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on amdt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module amdt_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire amdt_pkg::t_mem_req i_req,
    output amdt_pkg::t_entry        o_rd_data
);
    import amdt_pkg::*;

    t_entry                r_mem [STORE_ROWS];
    logic [STORE_ROWS-1:0] r_valid;
    t_entry                r_rd_data;
    logic                  r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_ok   <= r_valid[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    // The sequencer never reads the entry it writes in the same cycle.
    `ASSERT_IMPL(a_no_rw_clash, i_req.rd_en && i_req.wr_en, i_req.rd_addr != i_req.wr_addr)

endmodule

`default_nettype wire

FILE: sv/amdt_ctrl.sv
// Sequencer of the degree tracker: decodes an item, runs read-modify-write
// passes over the vertex store and holds the count and the highest degree.
// Depends on amdt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module amdt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_ready,
    input  wire amdt_pkg::t_cmd     i_cmd,
    output logic                    o_res_valid,
    input  wire logic               i_out_free,
    output amdt_pkg::t_result       o_res,
    output amdt_pkg::t_mem_req      o_req,
    input  wire amdt_pkg::t_entry   i_rd_data
);
    import amdt_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_deg   r_max,   n_max;
    t_cnt   r_idx,   n_idx;
    t_deg   r_best,  n_best;
    logic   r_status, n_status;
    logic   r_adj,    n_adj;
    logic   r_found,  n_found;
    t_vtx   r_iso,    n_iso;
    logic [2:0] r_act;
    t_vtx   r_a, r_b, r_rsp_idx;

    logic   a_over, b_over, pair_over, same, rem_bad, cnt_zero, last;
    t_cnt   a1, b1;
    logic   accept;

    // Edge insertion: the written row (r_a, then r_b) gets bit set_col.
    t_vtx   set_col;
    logic   set_hit;
    t_deg   set_deg;
    t_row   set_row_data;

    // Removal sweep terms for the response of entry r_rsp_idx.
    logic   rm_is_a, rm_hit;
    t_deg   rm_deg, rm_cand;

    assign accept    = i_cmd_valid && (r_state == ST_IDLE);
    assign a_over    = t_cnt'(i_cmd.vertex_a) >= t_cnt'(MAX_VERTICES);
    assign b_over    = t_cnt'(i_cmd.vertex_b) >= t_cnt'(MAX_VERTICES);
    assign pair_over = a_over || b_over;
    assign same      = i_cmd.vertex_a == i_cmd.vertex_b;
    assign rem_bad   = t_cnt'(i_cmd.vertex_a) >= r_count;
    assign cnt_zero  = r_count == '0;
    assign a1        = t_cnt'(i_cmd.vertex_a) + t_cnt'(1);
    assign b1        = t_cnt'(i_cmd.vertex_b) + t_cnt'(1);
    assign last      = r_idx == r_count;

    assign set_col      = (r_state == ST_EDGE_A) ? r_b : r_a;
    assign set_hit      = i_rd_data.row[set_col];
    assign set_deg      = set_hit ? i_rd_data.deg : t_deg'(i_rd_data.deg + t_deg'(1));
    assign set_row_data = i_rd_data.row | (t_row'(1) << set_col);

    assign rm_is_a = r_rsp_idx == r_a;
    assign rm_hit  = i_rd_data.row[r_a];
    assign rm_deg  = rm_is_a ? '0 : (rm_hit ? t_deg'(i_rd_data.deg - t_deg'(1))
                                            : i_rd_data.deg);
    assign rm_cand = (!rm_is_a && (rm_deg > r_best)) ? rm_deg : r_best;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.action)
                        ACT_ADD_EDGE: n_state = (pair_over || same) ? ST_DONE : ST_EDGE_A;
                        ACT_REMOVE:   n_state = rem_bad ? ST_DONE : ST_SWEEP;
                        ACT_QUERY:    n_state = (pair_over || same) ? ST_DONE : ST_QUERY;
                        ACT_FIND:     n_state = cnt_zero ? ST_DONE : ST_SWEEP;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_EDGE_A: n_state = ST_EDGE_B;
            ST_EDGE_B: n_state = ST_DONE;
            ST_QUERY:  n_state = ST_DONE;
            ST_SWEEP:  n_state = last ? ST_DONE : ST_SWEEP;
            ST_DONE:   n_state = i_out_free ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory requests.
    always_comb begin
        n_count  = r_count;
        n_max    = r_max;
        n_idx    = r_idx;
        n_best   = r_best;
        n_status = r_status;
        n_adj    = r_adj;
        n_found  = r_found;
        n_iso    = r_iso;
        o_req    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_status = 1'b0;
                    n_adj    = 1'b0;
                    n_found  = 1'b0;
                    n_iso    = '0;
                    n_best   = '0;
                    n_idx    = t_cnt'(1);
                    unique case (i_cmd.action)
                        ACT_ADD_VERTEX: begin
                            if (a_over) begin
                                n_status = 1'b1;
                            end else if (a1 > r_count) begin
                                n_count = a1;
                            end
                        end
                        ACT_ADD_EDGE: begin
                            if (pair_over) begin
                                n_status = 1'b1;
                            end else if (!same) begin
                                if (a1 > n_count) begin
                                    n_count = a1;
                                end
                                if (b1 > n_count) begin
                                    n_count = b1;
                                end
                                o_req.rd_en   = 1'b1;
                                o_req.rd_addr = i_cmd.vertex_a;
                            end
                        end
                        ACT_REMOVE: begin
                            if (rem_bad) begin
                                n_status = 1'b1;
                            end else begin
                                o_req.rd_en = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            if (pair_over) begin
                                n_status = 1'b1;
                            end else if (same) begin
                                n_adj = 1'b1;
                            end else begin
                                o_req.rd_en   = 1'b1;
                                o_req.rd_addr = i_cmd.vertex_a;
                            end
                        end
                        ACT_FIND: begin
                            o_req.rd_en = !cnt_zero;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EDGE_A, ST_EDGE_B: begin
                o_req.wr_en       = 1'b1;
                o_req.wr_addr     = (r_state == ST_EDGE_A) ? r_a : r_b;
                o_req.wr_data.row = set_row_data;
                o_req.wr_data.deg = set_deg;
                if (set_deg > r_max) begin
                    n_max = set_deg;
                end
                if (r_state == ST_EDGE_A) begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = r_b;
                end
            end
            ST_QUERY: begin
                n_adj = i_rd_data.row[r_b];
            end
            ST_SWEEP: begin
                if (r_act == ACT_REMOVE) begin
                    // The cleared vertex loses its whole row; each neighbor
                    // loses one column bit and one degree.
                    o_req.wr_en       = rm_is_a || rm_hit;
                    o_req.wr_addr     = r_rsp_idx;
                    o_req.wr_data.row = rm_is_a ? '0
                                                : (i_rd_data.row & ~(t_row'(1) << r_a));
                    o_req.wr_data.deg = rm_deg;
                    n_best            = rm_cand;
                    if (last) begin
                        n_max = rm_cand;
                    end
                end else if ((i_rd_data.deg == '0) && !r_found) begin
                    n_found = 1'b1;
                    n_iso   = r_rsp_idx;
                end
                if (!last) begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = r_idx[VTX_W-1:0];
                    n_idx         = r_idx + t_cnt'(1);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_best    <= n_best;
        r_status  <= n_status;
        r_adj     <= n_adj;
        r_found   <= n_found;
        r_iso     <= n_iso;
        r_rsp_idx <= o_req.rd_addr;
        if (accept) begin
            r_act <= i_cmd.action;
            r_a   <= i_cmd.vertex_a;
            r_b   <= i_cmd.vertex_b;
        end
    end

    assign o_cmd_ready           = r_state == ST_IDLE;
    assign o_res_valid           = r_state == ST_DONE;
    assign o_res.status          = r_status;
    assign o_res.adjacent        = r_adj;
    assign o_res.found           = r_found;
    assign o_res.isolated_vertex = r_iso;
    assign o_res.vertex_count    = r_count;
    assign o_res.highest_degree  = r_max[HDEG_W-1:0];

    `ASSERT_IMPL(a_sweep_idx, r_state == ST_SWEEP, r_idx <= r_count)
    `ASSERT_NEXT(a_count_grows, 1'b1, r_count >= $past(r_count))
    `ASSERT_IMPL(a_max_bound, r_count != '0, t_cnt'(r_max) < r_count)

endmodule

`default_nettype wire

FILE: sv/adjacency_matrix_degree_tracker_top.sv
// Top level of the adjacency matrix degree tracker: stream ports, the
// sequencer, the vertex store and the result register.
// Depends on amdt_pkg, amdt_ctrl, amdt_store and assert_macros.svh.
//
// Keeps an undirected graph of up to 64 vertices as a symmetric bit matrix
// with a degree per vertex, and answers one result item per input item.
// Items are taken one at a time. add_vertex, self loops, out-of-range cases,
// unknown codes and a query of a vertex against itself go straight to the
// result; any other query_adjacent reads one store row, and add_edge does
// one store read-modify-write per matrix row touched. remove_neighbours and
// find_isolated walk the store one row per cycle over the vertex_count rows.
// A finished result waits in the output register, so the next item can be
// taken while it is still pending; while that register is full and the sink
// stalls, a new result holds the sequencer in its done state. After reset
// the graph is empty at once; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module adjacency_matrix_degree_tracker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // vertex_a[5:0], vertex_b[11:6], zero pad
    input  wire logic [2:0]  s_tuser,  // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // status[0], adjacent[1], found[2],
                                       // isolated_vertex[8:3], vertex_count[15:9],
                                       // highest_degree[21:16], zero pad
);
    import amdt_pkg::*;

    t_cmd     cmd;
    t_result  res;
    logic     res_valid;
    logic     out_free;
    t_mem_req req;
    t_entry   rd_data;
    t_result  r_out;
    logic     r_out_valid;

    assign cmd.action   = s_tuser;
    assign cmd.vertex_a = s_tdata[5:0];
    assign cmd.vertex_b = s_tdata[11:6];

    assign out_free = !r_out_valid || m_tready;

    amdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_tvalid),
        .o_cmd_ready (s_tready),
        .i_cmd       (cmd),
        .o_res_valid (res_valid),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_req       (req),
        .i_rd_data   (rd_data)
    );

    amdt_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out.highest_degree, r_out.vertex_count,
                       r_out.isolated_vertex, r_out.found, r_out.adjacent,
                       r_out.status};

    // An accepted item takes the sequencer out of its idle state, so s_tready drops.
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
